FILE: rtl/wall_temperature_flux_balance_defines.svh
`ifndef WALL_TEMPERATURE_FLUX_BALANCE_DEFINES_SVH
`define WALL_TEMPERATURE_FLUX_BALANCE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define WTFB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WTFB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/wtfb_pkg.sv
package wtfb_pkg;

  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_ISO   = 3'd1;
  localparam logic [2:0] OP_GREY  = 3'd2;
  localparam logic [2:0] OP_REFL  = 3'd3;
  localparam logic [2:0] OP_FGREY = 3'd4;
  localparam logic [2:0] OP_FREFL = 3'd5;

  localparam int          CFG_IDX_W = 2;
  localparam int          CFG_DAT_W = 20;
  localparam logic [1:0]  REG_RELAX = 2'd0;
  localparam logic [1:0]  REG_FLOOR = 2'd1;
  localparam logic [1:0]  REG_CEIL  = 2'd2;
  localparam logic [15:0] RELAX_RST = 16'd6554;
  localparam logic [19:0] FLOOR_RST = 20'd0;
  localparam logic [19:0] CEIL_RST  = 20'hFFFFF;

  localparam logic [23:0] SIG_Q48 = 24'd15960476;
  localparam logic signed [42:0] BIG_MAG = 43'sd1099511627776;

  localparam int QUEUE_DEPTH = 2;

  localparam int DIVA_NW = 66;
  localparam int DIVA_DW = 46;
  localparam int DIVA_QB = 41;
  localparam int DIVB_NW = 57;
  localparam int DIVB_DW = 20;
  localparam int DIVB_QB = 32;

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_ISO,
    CLS_GREY,
    CLS_REFL,
    CLS_FGREY,
    CLS_FREFL
  } cls_t;

  typedef struct packed {
    logic [2:0]         op;
    logic [19:0]        prev_temp;
    logic [19:0]        reference_temp;
    logic [19:0]        exterior_temp;
    logic [23:0]        conductivity;
    logic [23:0]        thickness;
    logic [16:0]        emissivity;
    logic [31:0]        exchange_coef;
    logic signed [31:0] convective_flux;
    logic signed [31:0] incident_flux;
    logic signed [31:0] imposed_flux;
  } in_item_t;

  typedef struct packed {
    logic [19:0]        wall_temp;
    logic signed [31:0] conv_flux;
    logic signed [31:0] rad_flux;
    logic signed [31:0] rel_change;
    logic               relaxed;
    logic               clipped_low;
    logic               clipped_high;
    logic               decreasing;
    logic               known_type;
  } out_item_t;

  typedef struct packed {
    cls_t     cls;
    in_item_t f;
  } q_item_t;

  typedef struct packed {
    logic [15:0] relax_limit;
    logic [19:0] temp_floor;
    logic [19:0] temp_ceiling;
  } cfg_t;

  typedef struct packed {
    cls_t               cls;
    logic [19:0]        t;
    logic [19:0]        tref;
    logic signed [31:0] qc;
    logic signed [31:0] rad;
    logic [19:0]        step;
    logic               sgn;
    logic               dz;
    logic               nz;
  } tag_a_t;

  typedef struct packed {
    tag_a_t      a;
    logic [40:0] dmag;
  } tag_b_t;

endpackage

FILE: rtl/wtfb_front.sv
module wtfb_front import wtfb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_item_t in_item,
  input  logic     q_full,
  output logic     q_push,
  output q_item_t  q_item
);

  logic    fr_vld_r;
  q_item_t fr_item_r;
  cls_t    cls;
  logic    accept;

  always_comb begin
    unique case (in_item.op)
      OP_ISO:   cls = CLS_ISO;
      OP_GREY:  cls = CLS_GREY;
      OP_REFL:  cls = CLS_REFL;
      OP_FGREY: cls = CLS_FGREY;
      OP_FREFL: cls = CLS_FREFL;
      default:  cls = CLS_NONE;
    endcase
  end

  assign q_push = fr_vld_r && !q_full;
  assign busy   = fr_vld_r && q_full;
  assign accept = start && !busy;
  assign q_item = fr_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_vld_r <= 1'b0;
    end else if (accept) begin
      fr_vld_r <= 1'b1;
    end else if (q_push) begin
      fr_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_item_r.cls <= cls;
      fr_item_r.f   <= in_item;
    end
  end

endmodule

FILE: rtl/wtfb_fifo.sv
module wtfb_fifo import wtfb_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  output logic    pop_vld,
  output q_item_t pop_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULLC = CW'(DEPTH);

  q_item_t       mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          pop;

  assign full     = (count_r == FULLC);
  assign pop_vld  = (count_r != '0);
  assign pop      = pop_vld;
  assign pop_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      priority if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: rtl/wtfb_div.sv
module wtfb_div #(
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int QB = 8,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [TW-1:0] in_tag,
  output logic          out_vld,
  output logic [QB-1:0] out_quo,
  output logic [TW-1:0] out_tag
);

  localparam int RW = ((NW > DW + QB) ? NW : DW + QB) + 1;
  localparam int NS = QB + 1;
  localparam logic [QB-1:0] CAP = {1'b1, {(QB-1){1'b0}}};

  logic          vld_r [0:NS];
  logic [TW-1:0] tag_r [0:NS];
  logic [RW-1:0] rem_r [0:NS-1];
  logic [DW-1:0] den_r [0:NS-1];
  logic [QB-1:0] quo_r [1:NS];
  logic          ovf_r [1:NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
      vld_r[1] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
      vld_r[1] <= vld_r[0];
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= {{(RW-NW){1'b0}}, in_num};
    den_r[0] <= in_den;
    tag_r[0] <= in_tag;
    rem_r[1] <= rem_r[0];
    den_r[1] <= den_r[0];
    tag_r[1] <= tag_r[0];
    quo_r[1] <= '0;
    ovf_r[1] <= rem_r[0] >= ({{(RW-DW){1'b0}}, den_r[0]} << QB);
  end

  for (genvar s = 2; s <= NS; s++) begin : g_stage
    localparam int B = NS - s;
    logic [RW-1:0] dsh;
    logic          take;

    assign dsh  = {{(RW-DW){1'b0}}, den_r[s-1]} << B;
    assign take = !ovf_r[s-1] && (rem_r[s-1] >= dsh);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      tag_r[s] <= tag_r[s-1];
      ovf_r[s] <= ovf_r[s-1];
      quo_r[s] <= take ? (quo_r[s-1] | (QB'(1) << B)) : quo_r[s-1];
    end

    if (s < NS) begin : g_rem
      always_ff @(posedge clk) begin
        rem_r[s] <= take ? (rem_r[s-1] - dsh) : rem_r[s-1];
        den_r[s] <= den_r[s-1];
      end
    end
  end

  assign out_vld = vld_r[NS];
  assign out_tag = tag_r[NS];
  assign out_quo = (ovf_r[NS] || (quo_r[NS] > CAP)) ? CAP : quo_r[NS];

endmodule

FILE: rtl/wtfb_back.sv
`include "wall_temperature_flux_balance_defines.svh"

module wtfb_back import wtfb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      in_vld,
  input  q_item_t   in_q,
  output logic      out_strobe,
  output out_item_t out_item
);

  localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  // stage 1: squares, conduction and exchange products
  logic                s1_vld_r;
  q_item_t             s1_q_r;
  logic [19:0]         s1_ts_r;
  logic [39:0]         s1_t2_r;
  logic signed [45:0]  s1_kd_r;
  logic [55:0]         s1_eh_r;
  logic [19:0]         s1_step_r;
  logic [19:0]         ts_in;
  logic signed [20:0]  d_in;
  logic [35:0]         step_prod;

  assign ts_in = (in_q.cls == CLS_ISO) ? in_q.f.reference_temp : in_q.f.prev_temp;
  assign d_in  = $signed({1'b0, in_q.f.prev_temp}) - $signed({1'b0, in_q.f.exterior_temp});
  assign step_prod = in_q.f.prev_temp * cfg.relax_limit;

  always_ff @(posedge clk) begin
    s1_q_r    <= in_q;
    s1_ts_r   <= ts_in;
    s1_t2_r   <= ts_in * ts_in;
    s1_kd_r   <= $signed({1'b0, in_q.f.conductivity}) * d_in;
    s1_eh_r   <= in_q.f.thickness * in_q.f.exchange_coef;
    s1_step_r <= step_prod[35:16];
  end

  // stage 2: fourth power and cube
  logic                s2_vld_r;
  q_item_t             s2_q_r;
  logic [63:0]         s2_x2_r;
  logic [59:0]         s2_t3_r;
  logic signed [45:0]  s2_kd_r;
  logic [55:0]         s2_eh_r;
  logic [19:0]         s2_step_r;

  always_ff @(posedge clk) begin
    s2_q_r    <= s1_q_r;
    s2_x2_r   <= s1_t2_r[39:8] * s1_t2_r[39:8];
    s2_t3_r   <= s1_t2_r * s1_ts_r;
    s2_kd_r   <= s1_kd_r;
    s2_eh_r   <= s1_eh_r;
    s2_step_r <= s1_step_r;
  end

  // stage 3: scale by sigma
  logic                s3_vld_r;
  q_item_t             s3_q_r;
  logic [63:0]         s3_s4p_r;
  logic [63:0]         s3_s3p_r;
  logic signed [45:0]  s3_kd_r;
  logic [55:0]         s3_eh_r;
  logic [19:0]         s3_step_r;

  always_ff @(posedge clk) begin
    s3_q_r    <= s2_q_r;
    s3_s4p_r  <= s2_x2_r[63:24] * SIG_Q48;
    s3_s3p_r  <= s2_t3_r[59:20] * SIG_Q48;
    s3_kd_r   <= s2_kd_r;
    s3_eh_r   <= s2_eh_r;
    s3_step_r <= s2_step_r;
  end

  // stage 4: emissivity products
  logic                s4_vld_r;
  q_item_t             s4_q_r;
  logic signed [50:0]  s4_radp_r;
  logic [44:0]         s4_epsp_r;
  logic signed [45:0]  s4_kd_r;
  logic [55:0]         s4_eh_r;
  logic [19:0]         s4_step_r;
  logic signed [32:0]  rdiff;

  assign rdiff = $signed({s3_q_r.f.incident_flux[31], s3_q_r.f.incident_flux})
               - $signed({5'b0, s3_s4p_r[63:36]});

  always_ff @(posedge clk) begin
    s4_q_r    <= s3_q_r;
    s4_radp_r <= $signed({1'b0, s3_q_r.f.emissivity}) * rdiff;
    s4_epsp_r <= s3_q_r.f.emissivity * s3_s3p_r[63:36];
    s4_kd_r   <= s3_kd_r;
    s4_eh_r   <= s3_eh_r;
    s4_step_r <= s3_step_r;
  end

  // stage 5: radiative flux and linearized emission
  logic                s5_vld_r;
  q_item_t             s5_q_r;
  logic signed [31:0]  s5_rad_r;
  logic [28:0]         s5_epsg_r;
  logic signed [45:0]  s5_kd_r;
  logic [55:0]         s5_eh_r;
  logic [19:0]         s5_step_r;
  logic signed [34:0]  rsh;
  logic signed [31:0]  rsat;
  logic                rad_keep, eps_keep;

  assign rsh = $signed(s4_radp_r[50:16]);
  assign rad_keep = (s4_q_r.cls == CLS_ISO) || (s4_q_r.cls == CLS_GREY)
                 || (s4_q_r.cls == CLS_FGREY);
  assign eps_keep = (s4_q_r.cls == CLS_GREY) || (s4_q_r.cls == CLS_FGREY);

  always_comb begin
    priority if (rsh > 35'sh7FFFFFFF) begin
      rsat = S32_MAX;
    end else if (rsh < -35'sh80000000) begin
      rsat = S32_MIN;
    end else begin
      rsat = rsh[31:0];
    end
  end

  always_ff @(posedge clk) begin
    s5_q_r    <= s4_q_r;
    s5_rad_r  <= rad_keep ? rsat : '0;
    s5_epsg_r <= eps_keep ? s4_epsp_r[44:16] : '0;
    s5_kd_r   <= s4_kd_r;
    s5_eh_r   <= s4_eh_r;
    s5_step_r <= s4_step_r;
  end

  // stage 6: flux sums
  logic                s6_vld_r;
  q_item_t             s6_q_r;
  logic signed [31:0]  s6_rad_r;
  logic signed [32:0]  s6_sumq_r;
  logic signed [33:0]  s6_fnum_r;
  logic [52:0]         s6_eeps_r;
  logic [33:0]         s6_fden_r;
  logic signed [45:0]  s6_kd_r;
  logic [55:0]         s6_eh_r;
  logic [19:0]         s6_step_r;

  always_ff @(posedge clk) begin
    s6_q_r    <= s5_q_r;
    s6_rad_r  <= s5_rad_r;
    s6_sumq_r <= 33'(s5_q_r.f.convective_flux) + 33'(s5_rad_r);
    s6_fnum_r <= 34'(s5_q_r.f.convective_flux) + 34'(s5_rad_r)
               - 34'(s5_q_r.f.imposed_flux);
    s6_eeps_r <= s5_q_r.f.thickness * s5_epsg_r;
    s6_fden_r <= {3'b0, s5_epsg_r, 2'b00} + {2'b0, s5_q_r.f.exchange_coef};
    s6_kd_r   <= s5_kd_r;
    s6_eh_r   <= s5_eh_r;
    s6_step_r <= s5_step_r;
  end

  // stage 7: grey numerator product and denominator
  logic                s7_vld_r;
  q_item_t             s7_q_r;
  logic signed [31:0]  s7_rad_r;
  logic signed [57:0]  s7_esum_r;
  logic [45:0]         s7_deng_r;
  logic signed [33:0]  s7_fnum_r;
  logic [33:0]         s7_fden_r;
  logic signed [45:0]  s7_kd_r;
  logic [19:0]         s7_step_r;

  always_ff @(posedge clk) begin
    s7_q_r    <= s6_q_r;
    s7_rad_r  <= s6_rad_r;
    s7_esum_r <= $signed({1'b0, s6_q_r.f.thickness}) * s6_sumq_r;
    s7_deng_r <= {2'b0, s6_q_r.f.conductivity, 20'b0} + {3'b0, s6_eeps_r[52:10]}
               + {2'b0, s6_eh_r[55:12]};
    s7_fnum_r <= s6_fnum_r;
    s7_fden_r <= s6_fden_r;
    s7_kd_r   <= s6_kd_r;
    s7_step_r <= s6_step_r;
  end

  // stage 8: grey numerator
  logic                s8_vld_r;
  q_item_t             s8_q_r;
  logic signed [31:0]  s8_rad_r;
  logic signed [58:0]  s8_numg_r;
  logic [45:0]         s8_deng_r;
  logic signed [33:0]  s8_fnum_r;
  logic [33:0]         s8_fden_r;
  logic [19:0]         s8_step_r;

  always_ff @(posedge clk) begin
    s8_q_r    <= s7_q_r;
    s8_rad_r  <= s7_rad_r;
    s8_numg_r <= 59'(s7_esum_r) - 59'($signed({s7_kd_r, 12'b0}));
    s8_deng_r <= s7_deng_r;
    s8_fnum_r <= s7_fnum_r;
    s8_fden_r <= s7_fden_r;
    s8_step_r <= s7_step_r;
  end

  // divider operand select
  logic [57:0]         numg_mag;
  logic [33:0]         fnum_mag;
  logic [31:0]         qimp_mag;
  logic [DIVA_NW-1:0]  da_num;
  logic [DIVA_DW-1:0]  da_den;
  tag_a_t              da_tag;
  logic                da_sgn, da_dz;

  assign numg_mag = s8_numg_r[58] ? 58'(-s8_numg_r) : s8_numg_r[57:0];
  assign fnum_mag = s8_fnum_r[33] ? 34'(-s8_fnum_r) : s8_fnum_r;
  assign qimp_mag = s8_q_r.f.imposed_flux[31] ? 32'(-s8_q_r.f.imposed_flux)
                                              : s8_q_r.f.imposed_flux;

  always_comb begin
    unique case (s8_q_r.cls)
      CLS_GREY, CLS_REFL: begin
        da_num = {numg_mag, 8'b0};
        da_den = s8_deng_r;
        da_sgn = s8_numg_r[58];
        da_dz  = (s8_deng_r == '0);
      end
      CLS_FGREY: begin
        da_num = {12'b0, fnum_mag, 20'b0};
        da_den = {12'b0, s8_fden_r};
        da_sgn = s8_fnum_r[33];
        da_dz  = (s8_fden_r == '0);
      end
      CLS_FREFL: begin
        da_num = {14'b0, qimp_mag, 20'b0};
        da_den = {14'b0, s8_q_r.f.exchange_coef};
        da_sgn = s8_q_r.f.imposed_flux[31];
        da_dz  = (s8_q_r.f.exchange_coef == '0);
      end
      default: begin
        da_num = '0;
        da_den = '0;
        da_sgn = 1'b0;
        da_dz  = 1'b1;
      end
    endcase
  end

  assign da_tag.cls  = s8_q_r.cls;
  assign da_tag.t    = s8_q_r.f.prev_temp;
  assign da_tag.tref = s8_q_r.f.reference_temp;
  assign da_tag.qc   = s8_q_r.f.convective_flux;
  assign da_tag.rad  = s8_rad_r;
  assign da_tag.step = s8_step_r;
  assign da_tag.sgn  = da_sgn;
  assign da_tag.dz   = da_dz;
  assign da_tag.nz   = (da_num != '0);

  logic               qa_vld;
  logic [DIVA_QB-1:0] qa_quo;
  tag_a_t             qa_tag;

  wtfb_div #(
    .NW (DIVA_NW),
    .DW (DIVA_DW),
    .QB (DIVA_QB),
    .TW ($bits(tag_a_t))
  ) u_div_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s8_vld_r),
    .in_num  (da_num),
    .in_den  (da_den),
    .in_tag  (da_tag),
    .out_vld (qa_vld),
    .out_quo (qa_quo),
    .out_tag (qa_tag)
  );

  // increment magnitude
  logic        c1_vld_r;
  tag_a_t      c1_tag_r;
  logic [40:0] c1_dmag_r;
  tag_b_t      db_tag;

  always_ff @(posedge clk) begin
    c1_tag_r  <= qa_tag;
    c1_dmag_r <= qa_tag.dz ? '0 : qa_quo;
  end

  assign db_tag.a    = c1_tag_r;
  assign db_tag.dmag = c1_dmag_r;

  logic               qb_vld;
  logic [DIVB_QB-1:0] qb_quo;
  tag_b_t             qb_tag;

  wtfb_div #(
    .NW (DIVB_NW),
    .DW (DIVB_DW),
    .QB (DIVB_QB),
    .TW ($bits(tag_b_t))
  ) u_div_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (c1_vld_r),
    .in_num  ({c1_dmag_r, 16'b0}),
    .in_den  (c1_tag_r.t),
    .in_tag  (db_tag),
    .out_vld (qb_vld),
    .out_quo (qb_quo),
    .out_tag (qb_tag)
  );

  // relative change and candidate temperatures
  logic               d1_vld_r;
  tag_a_t             d1_a_r;
  logic signed [31:0] d1_rapp_r;
  logic signed [42:0] d1_wplain_r;
  logic signed [42:0] d1_w5_r;
  logic [20:0]        d1_tp_r;
  logic [19:0]        d1_tm_r;
  logic signed [31:0] rapp;
  logic signed [42:0] detep;
  logic signed [42:0] w5;

  always_comb begin
    priority if (qb_tag.a.t == '0) begin
      rapp = (qb_tag.dmag == '0) ? '0 : (qb_tag.a.sgn ? S32_MIN : S32_MAX);
    end else if (qb_tag.a.sgn) begin
      rapp = 32'(-qb_quo);
    end else begin
      rapp = qb_quo[31] ? S32_MAX : qb_quo;
    end
  end

  assign detep = qb_tag.a.sgn ? -$signed({2'b0, qb_tag.dmag}) : $signed({2'b0, qb_tag.dmag});

  always_comb begin
    priority if (!qb_tag.a.dz) begin
      w5 = $signed({23'b0, qb_tag.a.tref}) - detep;
    end else if (qb_tag.a.sgn) begin
      w5 = BIG_MAG;
    end else if (qb_tag.a.nz) begin
      w5 = -BIG_MAG;
    end else begin
      w5 = '0;
    end
  end

  always_ff @(posedge clk) begin
    d1_a_r      <= qb_tag.a;
    d1_rapp_r   <= rapp;
    d1_wplain_r <= $signed({23'b0, qb_tag.a.t}) + detep;
    d1_w5_r     <= w5;
    d1_tp_r     <= {1'b0, qb_tag.a.t} + {1'b0, qb_tag.a.step};
    d1_tm_r     <= qb_tag.a.t - qb_tag.a.step;
  end

  // relaxation and type select
  logic               d2_vld_r;
  logic signed [42:0] d2_wall_r;
  logic               d2_clip_r;
  out_item_t          d2_res_r;
  logic [32:0]        magr;
  logic               relax;
  logic signed [42:0] wall;
  logic               clip;
  out_item_t          res;

  assign magr  = d1_rapp_r[31] ? 33'(-$signed({d1_rapp_r[31], d1_rapp_r}))
                               : {1'b0, d1_rapp_r};
  assign relax = (d1_rapp_r != '0) && (magr >= {17'b0, cfg.relax_limit});

  always_comb begin
    res            = '0;
    res.known_type = 1'b1;
    res.conv_flux  = d1_a_r.qc;
    res.rad_flux   = d1_a_r.rad;
    wall           = $signed({23'b0, d1_a_r.t});
    clip           = 1'b0;
    unique case (d1_a_r.cls)
      CLS_ISO: begin
        wall = $signed({23'b0, d1_a_r.tref});
      end
      CLS_GREY, CLS_REFL, CLS_FGREY: begin
        priority if (relax && (d1_rapp_r > 0)) begin
          wall = $signed({22'b0, d1_tp_r});
        end else if (relax) begin
          wall = $signed({23'b0, d1_tm_r});
        end else begin
          wall = d1_wplain_r;
        end
        clip           = 1'b1;
        res.rel_change = d1_rapp_r;
        res.relaxed    = relax;
        res.decreasing = (d1_rapp_r <= 0);
      end
      CLS_FREFL: begin
        wall = d1_w5_r;
        clip = 1'b1;
      end
      default: begin
        res            = '0;
        wall           = $signed({23'b0, d1_a_r.t});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    d2_wall_r <= wall;
    d2_clip_r <= clip;
    d2_res_r  <= res;
  end

  // clipping and output register
  logic               out_vld_r;
  out_item_t          out_item_r;
  logic               lo, hi;
  logic signed [42:0] w1, w2;
  out_item_t          fin;

  assign lo = d2_clip_r && (d2_wall_r < $signed({23'b0, cfg.temp_floor}));
  assign w1 = lo ? $signed({23'b0, cfg.temp_floor}) : d2_wall_r;
  assign hi = d2_clip_r && (w1 > $signed({23'b0, cfg.temp_ceiling}));
  assign w2 = hi ? $signed({23'b0, cfg.temp_ceiling}) : w1;

  always_comb begin
    fin              = d2_res_r;
    fin.wall_temp    = w2[19:0];
    fin.clipped_low  = lo;
    fin.clipped_high = hi;
  end

  always_ff @(posedge clk) begin
    out_item_r <= fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      s6_vld_r  <= 1'b0;
      s7_vld_r  <= 1'b0;
      s8_vld_r  <= 1'b0;
      c1_vld_r  <= 1'b0;
      d1_vld_r  <= 1'b0;
      d2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= in_vld;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
      s5_vld_r  <= s4_vld_r;
      s6_vld_r  <= s5_vld_r;
      s7_vld_r  <= s6_vld_r;
      s8_vld_r  <= s7_vld_r;
      c1_vld_r  <= qa_vld;
      d1_vld_r  <= qb_vld;
      d2_vld_r  <= d1_vld_r;
      out_vld_r <= d2_vld_r;
    end
  end

  assign out_strobe = out_vld_r;
  assign out_item   = out_item_r;

  `WTFB_ASSERT_IMPL(a_unknown_quiet, out_strobe && !out_item.known_type, (out_item.conv_flux == 0) && (out_item.rad_flux == 0) && (out_item.rel_change == 0) && !out_item.relaxed && !out_item.clipped_low && !out_item.clipped_high && !out_item.decreasing, "unknown wall type with nonzero result")
  `WTFB_ASSERT_IMPL(a_clip_high, out_strobe && out_item.clipped_high, out_item.wall_temp == cfg.temp_ceiling, "ceiling clip mismatch")
  `WTFB_ASSERT_IMPL(a_clip_low, out_strobe && out_item.clipped_low && !out_item.clipped_high, out_item.wall_temp == cfg.temp_floor, "floor clip mismatch")
  `WTFB_ASSERT_IMPL(a_relax_known, out_strobe && out_item.relaxed, out_item.known_type && (out_item.rel_change != 0), "relaxed without relative change")
  `WTFB_ASSERT_NEXT(a_tail_flow, d1_vld_r, d2_vld_r, "item lost in output stages")

endmodule

FILE: rtl/wall_temperature_flux_balance.sv
// Wall temperature flux balance, one boundary face per item.
// Input: an item is taken at a rising edge with start high and busy low.
// Faces may be issued every cycle; busy only rises if the internal queue
// between the classifier and the arithmetic pipeline fills, which the
// never-stalling pipeline prevents in normal use.
// Output: each result appears on out_item for one cycle with out_strobe high,
// in issue order. Throughput is one item per cycle; the 41-step increment
// divider and the 32-step relative-change divider are both fully pipelined.
// The receiver cannot stall: results are not held.
// Configuration: cfg_we writes cfg_wdata into register cfg_idx (0 relax limit,
// 1 floor, 2 ceiling) at the clock edge; write only while no item is in flight.
// Reset (rst_n low, synchronous) empties the queue and pipeline and restores
// the register defaults.
module wall_temperature_flux_balance import wtfb_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item,
  output logic                 out_strobe,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  cfg_t    cfg_r;
  logic    q_full, q_push, pop_vld;
  q_item_t q_item, pop_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.relax_limit  <= RELAX_RST;
      cfg_r.temp_floor   <= FLOOR_RST;
      cfg_r.temp_ceiling <= CEIL_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_RELAX: cfg_r.relax_limit  <= cfg_wdata[15:0];
        REG_FLOOR: cfg_r.temp_floor   <= cfg_wdata;
        REG_CEIL:  cfg_r.temp_ceiling <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  wtfb_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_item  (q_item)
  );

  wtfb_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop_vld   (pop_vld),
    .pop_item  (pop_item)
  );

  wtfb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_vld     (pop_vld),
    .in_q       (pop_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule
